// ----- src/lrupr_pkg.sv -----
package lrupr_pkg;

    // build defaults
    localparam int MAX_FRAMES_DEF = 8;
    localparam int PAGE_BITS_DEF  = 16;

    // fixed field widths
    localparam int PAGE_IN_W = 16;
    localparam int COUNT_W   = 32;
    localparam int FRAMES_W  = 4;

    // config port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_FRAMES_IN_USE = 1'b0;   // register index, paddr[2]

    localparam logic [FRAMES_W-1:0] FRAMES_RESET = 4'd3;
    localparam logic [COUNT_W-1:0]  COUNT_MAX    = '1;

    typedef struct packed {
        logic hit;
        logic ev_valid;
    } t_upd_flags;

endpackage

// ----- src/lru_page_replacement.sv -----
// Channel  | Handshake              | Payload
// ---------+------------------------+--------------------------------------------
// in       | i_in_valid/o_in_ready  | i_page_number
// out      | o_out_valid/i_out_ready| o_fault, o_evicted_valid, o_evicted_page,
//          |                        | o_fault_count
// config   | APB psel/penable/...   | frames_in_use at byte address 0
//
// Each word has its stack row read from the stack memory in S_IDLE, then is
// compared/shifted and written back into the same memory in S_CALC.
// The next word is taken right after write-back; results sit in an output
// register, so a waiting result does not block the next accept.
// A word stalls in the compute cycle only while an older result is unread.
// Reset (sync, active low) empties all frames and clears the fault count;
// frames_in_use returns to 3. No clearing pass is needed.
module lru_page_replacement #(
    parameter int MAX_FRAMES = lrupr_pkg::MAX_FRAMES_DEF,
    parameter int PAGE_BITS  = lrupr_pkg::PAGE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // page references
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [lrupr_pkg::PAGE_IN_W-1:0]  i_page_number,
    // results
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_fault,
    output logic                             o_evicted_valid,
    output logic [lrupr_pkg::PAGE_IN_W-1:0]  o_evicted_page,
    output logic [lrupr_pkg::COUNT_W-1:0]    o_fault_count,
    // config
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lrupr_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [lrupr_pkg::APB_DATA_W-1:0] pwdata,
    output logic [lrupr_pkg::APB_DATA_W-1:0] prdata,
    output logic                             pready
);
    import lrupr_pkg::*;

    localparam int ROW_W = MAX_FRAMES * PAGE_BITS;
    localparam int IW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int NW    = $clog2(MAX_FRAMES + 1);
    localparam int CW    = (NW > FRAMES_W) ? NW : FRAMES_W;

    typedef enum logic {
        S_IDLE,
        S_CALC
    } t_state;

    t_state                r_state;
    logic [FRAMES_W-1:0]   r_frames;
    logic [PAGE_BITS-1:0]  r_page;
    logic [MAX_FRAMES-1:0] r_valid;    // frame occupancy, cleared by reset
    logic [COUNT_W-1:0]    r_count;
    logic                  r_out_valid;
    logic                  r_fault;
    logic                  r_ev_valid;
    logic [PAGE_IN_W-1:0]  r_ev_page;

    logic                  in_acc;
    logic                  out_free;
    logic                  commit;
    logic                  reg_wr;
    logic [CW-1:0]         frames_ext;
    logic [CW-1:0]         n_act;
    logic [IW-1:0]         last;
    logic [ROW_W-1:0]      rd_row;
    logic [ROW_W-1:0]      wr_row;
    logic [MAX_FRAMES-1:0] n_valid;
    logic [PAGE_BITS-1:0]  ev_page;
    logic [COUNT_W-1:0]    n_count;
    t_upd_flags            flags;

    // ---- config register ----
    assign pready = 1'b1;
    assign reg_wr = psel && penable && pwrite && (paddr[2] == REG_FRAMES_IN_USE);
    assign prdata = (paddr[2] == REG_FRAMES_IN_USE) ? APB_DATA_W'(r_frames) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames <= FRAMES_RESET;
        end else if (reg_wr) begin
            r_frames <= pwdata[FRAMES_W-1:0];
        end
    end

    // active frame count: zero acts as one, clipped to the built depth
    always_comb begin
        frames_ext = CW'(r_frames);
        if (frames_ext == '0) begin
            n_act = CW'(1);
        end else if (frames_ext > CW'(MAX_FRAMES)) begin
            n_act = CW'(MAX_FRAMES);
        end else begin
            n_act = frames_ext;
        end
        last = IW'(n_act - CW'(1));
    end

    // ---- handshake ----
    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign commit     = (r_state == S_CALC) && out_free;

    // ---- stack memory and update datapath ----
    lrupr_stack_mem #(
        .ROW_W(ROW_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rd_en (in_acc),
        .i_wr_en (commit),
        .i_wr_row(wr_row),
        .o_rd_row(rd_row)
    );

    lrupr_update #(
        .MAX_FRAMES(MAX_FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_upd (
        .i_row    (rd_row),
        .i_valid  (r_valid),
        .i_page   (r_page),
        .i_last   (last),
        .o_row    (wr_row),
        .o_valid  (n_valid),
        .o_ev_page(ev_page),
        .o_flags  (flags)
    );

    // saturating fault count
    assign n_count = (!flags.hit && r_count != COUNT_MAX) ? r_count + COUNT_W'(1) : r_count;

    // ---- control and result register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_fault     <= 1'b0;
            r_ev_valid  <= 1'b0;
            r_ev_page   <= '0;
        end else begin
            // a new result replaces the one being read in the same cycle
            if (i_out_ready && !commit) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_CALC;
                        r_page  <= PAGE_BITS'(i_page_number);
                    end
                end
                S_CALC: begin
                    if (out_free) begin
                        r_state     <= S_IDLE;
                        r_valid     <= n_valid;
                        r_count     <= n_count;
                        r_out_valid <= 1'b1;
                        r_fault     <= !flags.hit;
                        r_ev_valid  <= flags.ev_valid;
                        r_ev_page   <= PAGE_IN_W'(ev_page);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_fault         = r_fault;
    assign o_evicted_valid = r_ev_valid;
    assign o_evicted_page  = r_ev_page;
    assign o_fault_count   = r_count;

endmodule

// ----- src/lrupr_stack_mem.sv -----
module lrupr_stack_mem #(
    parameter int ROW_W = 128
) (
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic             i_wr_en,
    input  logic [ROW_W-1:0] i_wr_row,
    output logic [ROW_W-1:0] o_rd_row
);

    // single-row store holding the whole recency stack; registered read
    logic [ROW_W-1:0] r_mem;
    logic [ROW_W-1:0] r_rd_row;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem <= i_wr_row;
        end
        if (i_rd_en) begin
            r_rd_row <= r_mem;
        end
    end

    assign o_rd_row = r_rd_row;

endmodule

// ----- src/lrupr_update.sv -----
module lrupr_update #(
    parameter int MAX_FRAMES = 8,
    parameter int PAGE_BITS  = 16,
    localparam int ROW_W     = MAX_FRAMES * PAGE_BITS,
    localparam int IW        = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1
) (
    input  logic [ROW_W-1:0]      i_row,
    input  logic [MAX_FRAMES-1:0] i_valid,
    input  logic [PAGE_BITS-1:0]  i_page,
    input  logic [IW-1:0]         i_last,      // index of last active position
    output logic [ROW_W-1:0]      o_row,
    output logic [MAX_FRAMES-1:0] o_valid,
    output logic [PAGE_BITS-1:0]  o_ev_page,
    output lrupr_pkg::t_upd_flags o_flags
);
    import lrupr_pkg::*;

    logic [PAGE_BITS-1:0]  pages [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] match;
    logic [IW-1:0]         hit_pos;
    logic [IW-1:0]         top;
    logic                  hit;

    always_comb begin
        for (int k = 0; k < MAX_FRAMES; k++) begin
            pages[k] = i_row[k*PAGE_BITS +: PAGE_BITS];
            match[k] = i_valid[k] && (pages[k] == i_page) && (k <= int'(i_last));
        end
    end

    // lowest matching position wins
    always_comb begin
        hit     = 1'b0;
        hit_pos = '0;
        for (int k = MAX_FRAMES - 1; k >= 0; k--) begin
            if (match[k]) begin
                hit     = 1'b1;
                hit_pos = IW'(k);
            end
        end
    end

    assign top = hit ? hit_pos : i_last;

    always_comb begin
        o_row   = i_row;
        o_valid = i_valid;
        o_row[0 +: PAGE_BITS] = i_page;
        o_valid[0]            = 1'b1;
        for (int k = 1; k < MAX_FRAMES; k++) begin
            if (k <= int'(top)) begin
                o_row[k*PAGE_BITS +: PAGE_BITS] = pages[k-1];
                o_valid[k]                      = i_valid[k-1];
            end
        end
    end

    always_comb begin
        o_flags.hit      = hit;
        o_flags.ev_valid = !hit && i_valid[i_last];
        o_ev_page        = o_flags.ev_valid ? pages[i_last] : '0;
    end

endmodule
